@@ rtl/smpq_pkg.sv @@
`default_nettype none

package smpq_pkg;

    localparam int KEY_BITS = 32;
    localparam int OCC_BITS = 7;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/smpq_cell.sv @@
`default_nettype none

module smpq_cell #(
    parameter int TILE_BITS = 16
) (
    input  wire                         i_clk,
    input  wire smpq_pkg::t_cell_ctrl   i_ctrl,
    input  wire [smpq_pkg::KEY_BITS-1:0] i_key,
    input  wire [TILE_BITS-1:0]         i_tile,
    input  wire                         i_occ,
    input  wire                         i_prev_ins,
    input  wire [smpq_pkg::KEY_BITS-1:0] i_prev_key,
    input  wire [TILE_BITS-1:0]         i_prev_tile,
    input  wire [smpq_pkg::KEY_BITS-1:0] i_next_key,
    input  wire [TILE_BITS-1:0]         i_next_tile,
    output logic                        o_ins,
    output logic [smpq_pkg::KEY_BITS-1:0] o_key,
    output logic [TILE_BITS-1:0]        o_tile,
    output logic [smpq_pkg::KEY_BITS-1:0] o_nxt_key,
    output logic [TILE_BITS-1:0]        o_nxt_tile
);
    import smpq_pkg::*;

    logic [KEY_BITS-1:0]  r_key;
    logic [TILE_BITS-1:0] r_tile;
    logic [KEY_BITS-1:0]  n_key;
    logic [TILE_BITS-1:0] n_tile;
    logic                 w_ins;

    // insertion point: first empty cell or first cell with key >= new key
    assign w_ins = !i_occ || (r_key >= i_key);

    always_comb begin
        n_key  = r_key;
        n_tile = r_tile;
        if (i_ctrl.push && w_ins) begin
            if (i_prev_ins) begin
                n_key  = i_prev_key;
                n_tile = i_prev_tile;
            end else begin
                n_key  = i_key;
                n_tile = i_tile;
            end
        end else if (i_ctrl.pop) begin
            n_key  = i_next_key;
            n_tile = i_next_tile;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_tile <= n_tile;
    end

    assign o_ins      = w_ins;
    assign o_key      = r_key;
    assign o_tile     = r_tile;
    assign o_nxt_key  = n_key;
    assign o_nxt_tile = n_tile;

endmodule

`default_nettype wire

@@ rtl/sorted_min_priority_queue.sv @@
// Sorted minimum priority queue of (key, tile) pairs, built as a row of cells.
// Cell 0 always holds the smallest key; equal keys are served newest first.
// Input channel: i_in_valid / o_in_stall with i_req_type (push or pop), i_key
// (UQ16.16) and i_tile. A request is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall, one result per request carrying
// the popped pair, the new top, the empty flag, occupancy and status.
// A result is registered for the cycle after its request is taken. One request
// is taken every cycle unless the receiver stalls; every cell compares its key
// with the broadcast key at once and shifts toward or away from its neighbor.
// A push into a full queue is dropped with status 1; a pop on an empty queue
// reports status 2 and zero pairs.
// Reset empties the queue and clears the output valid; cell contents are
// not cleared, only the entry count.
// While the receiver stalls, the pending result holds and the input stalls.
`default_nettype none

module sorted_min_priority_queue #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int TILE_ID_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_req_type,
    input  wire [smpq_pkg::KEY_BITS-1:0]  i_key,
    input  wire [TILE_ID_BITS-1:0]        i_tile,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [smpq_pkg::KEY_BITS-1:0] o_popped_key,
    output logic [TILE_ID_BITS-1:0]       o_popped_tile,
    output logic [smpq_pkg::KEY_BITS-1:0] o_top_key,
    output logic [TILE_ID_BITS-1:0]       o_top_tile,
    output logic                          o_is_empty,
    output logic [smpq_pkg::OCC_BITS-1:0] o_occupancy,
    output logic [1:0]                    o_status
);
    import smpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int OW = CW + OCC_BITS;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    t_cell_ctrl           w_ctrl;
    t_status              w_status;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [OW-1:0]        w_count_ext;

    logic [QUEUE_DEPTH-1:0] w_occ;
    logic [QUEUE_DEPTH-1:0] w_ins;
    logic [KEY_BITS-1:0]    w_key     [QUEUE_DEPTH];
    logic [TILE_ID_BITS-1:0] w_tile   [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]    w_nxt_key [QUEUE_DEPTH];
    logic [TILE_ID_BITS-1:0] w_nxt_tile [QUEUE_DEPTH];

    logic                    r_out_valid;
    logic [KEY_BITS-1:0]     r_popped_key;
    logic [TILE_ID_BITS-1:0] r_popped_tile;
    logic [KEY_BITS-1:0]     r_top_key;
    logic [TILE_ID_BITS-1:0] r_top_tile;
    logic                    r_is_empty;
    logic [CW-1:0]           r_occ;
    t_status                 r_status;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctrl   = '0;
        w_status = ST_OK;
        n_count  = r_count;
        if (w_accept) begin
            unique case (i_req_type)
                REQ_PUSH: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctrl.push = 1'b1;
                        n_count     = r_count + CW'(1);
                    end
                end
                REQ_POP: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_ctrl.pop = 1'b1;
                        n_count    = r_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
        logic                    w_prev_ins;
        logic [KEY_BITS-1:0]     w_prev_key;
        logic [TILE_ID_BITS-1:0] w_prev_tile;
        logic [KEY_BITS-1:0]     w_next_key;
        logic [TILE_ID_BITS-1:0] w_next_tile;

        assign w_occ[j] = (CW'(j) < r_count);

        if (j == 0) begin : g_first
            assign w_prev_ins  = 1'b0;
            assign w_prev_key  = i_key;
            assign w_prev_tile = i_tile;
        end else begin : g_mid
            assign w_prev_ins  = w_ins[j-1];
            assign w_prev_key  = w_key[j-1];
            assign w_prev_tile = w_tile[j-1];
        end

        if (j == QUEUE_DEPTH - 1) begin : g_last
            assign w_next_key  = w_key[j];
            assign w_next_tile = w_tile[j];
        end else begin : g_inner
            assign w_next_key  = w_key[j+1];
            assign w_next_tile = w_tile[j+1];
        end

        smpq_cell #(
            .TILE_BITS (TILE_ID_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_key       (i_key),
            .i_tile      (i_tile),
            .i_occ       (w_occ[j]),
            .i_prev_ins  (w_prev_ins),
            .i_prev_key  (w_prev_key),
            .i_prev_tile (w_prev_tile),
            .i_next_key  (w_next_key),
            .i_next_tile (w_next_tile),
            .o_ins       (w_ins[j]),
            .o_key       (w_key[j]),
            .o_tile      (w_tile[j]),
            .o_nxt_key   (w_nxt_key[j]),
            .o_nxt_tile  (w_nxt_tile[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped_key  <= w_ctrl.pop ? w_key[0] : '0;
            r_popped_tile <= w_ctrl.pop ? w_tile[0] : '0;
            r_top_key     <= (n_count == '0) ? '0 : w_nxt_key[0];
            r_top_tile    <= (n_count == '0) ? '0 : w_nxt_tile[0];
            r_is_empty    <= (n_count == '0);
            r_occ         <= n_count;
            r_status      <= w_status;
        end
    end

    assign w_count_ext   = OW'(r_occ);
    assign o_out_valid   = r_out_valid;
    assign o_popped_key  = r_popped_key;
    assign o_popped_tile = r_popped_tile;
    assign o_top_key     = r_top_key;
    assign o_top_tile    = r_top_tile;
    assign o_is_empty    = r_is_empty;
    assign o_occupancy   = w_count_ext[OCC_BITS-1:0];
    assign o_status      = r_status;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int TILE_BITS    = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 200;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [KEY_BITS-1:0]  popped_key;
        logic [TILE_BITS-1:0] popped_tile;
        logic [KEY_BITS-1:0]  top_key;
        logic [TILE_BITS-1:0] top_tile;
        logic                 is_empty;
        logic [OCC_BITS-1:0]  occupancy;
        t_status              status;
    } t_pq_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_req_type  = REQ_PUSH;
    logic [KEY_BITS-1:0]   i_key       = '0;
    logic [TILE_BITS-1:0]  i_tile      = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [KEY_BITS-1:0]   o_popped_key;
    logic [TILE_BITS-1:0]  o_popped_tile;
    logic [KEY_BITS-1:0]   o_top_key;
    logic [TILE_BITS-1:0]  o_top_tile;
    logic                  o_is_empty;
    logic [OCC_BITS-1:0]   o_occupancy;
    logic [1:0]            o_status;

    // predictor state
    logic [KEY_BITS-1:0]  model_key [DEPTH];
    logic [TILE_BITS-1:0] model_tile[DEPTH];
    int                   model_count = 0;

    t_pq_result pending_results[$];
    int         error_count  = 0;
    int         stuck_cycles = 0;

    // idling controls, written by the test tasks and the receiver stall process
    int unsigned gap_max     = 0;
    int unsigned stall_pct   = 0;
    int unsigned burst_left  = 0;
    int unsigned hold_asked  = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;

    sorted_min_priority_queue #(
        .QUEUE_DEPTH  (DEPTH),
        .TILE_ID_BITS (TILE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_tile        (i_tile),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_popped_key  (o_popped_key),
        .o_popped_tile (o_popped_tile),
        .o_top_key     (o_top_key),
        .o_top_tile    (o_top_tile),
        .o_is_empty    (o_is_empty),
        .o_occupancy   (o_occupancy),
        .o_status      (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_pq_result queue_model_step(input logic req,
                                                    input logic [KEY_BITS-1:0] key,
                                                    input logic [TILE_BITS-1:0] tile);
        t_pq_result r;
        int pos;
        r = '0;
        r.status = ST_OK;
        if (req == REQ_PUSH) begin
            if (model_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = model_count;
                for (int i = 0; i < model_count; i++) begin
                    if (model_key[i] < key) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = model_count; i > pos; i--) begin
                    model_key[i]  = model_key[i-1];
                    model_tile[i] = model_tile[i-1];
                end
                model_key[pos]  = key;
                model_tile[pos] = tile;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                model_count--;
                r.popped_key  = model_key[model_count];
                r.popped_tile = model_tile[model_count];
            end
        end
        if (model_count > 0) begin
            r.top_key  = model_key[model_count-1];
            r.top_tile = model_tile[model_count-1];
        end
        r.is_empty  = (model_count == 0);
        r.occupancy = OCC_BITS'(model_count);
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [KEY_BITS-1:0] k;
        case ($urandom_range(0, 4))
            0: k = $urandom_range(0, 7);
            1: k = $urandom_range(0, 1) ? '1 : '0;
            2: k = {16'($urandom_range(0, 15)), 16'h0000};
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic send_req(input logic req, input logic [KEY_BITS-1:0] key,
                            input logic [TILE_BITS-1:0] tile);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        i_tile     <= tile;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.insert(pending_results.size(), queue_model_step(req, key, tile));
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic check_field(input string name, input logic [KEY_BITS-1:0] want,
                               input logic [KEY_BITS-1:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= PRINT_LIMIT)
                $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
        end
    endtask

    // result checker and stuck-run watchdog
    always @(posedge i_clk) begin
        t_pq_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: expected none actual top %h occ %0d",
                             $realtime, o_top_key, o_occupancy);
                end else begin
                    want = pending_results.pop_front();
                    check_field("popped_key",  want.popped_key,  o_popped_key);
                    check_field("popped_tile", want.popped_tile, o_popped_tile);
                    check_field("top_key",     want.top_key,     o_top_key);
                    check_field("top_tile",    want.top_tile,    o_top_tile);
                    check_field("is_empty",    want.is_empty,    o_is_empty);
                    check_field("occupancy",   want.occupancy,   o_occupancy);
                    check_field("status",      want.status,      o_status);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (!i_in_valid && pending_results.size() == 0)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("[sorted_min_priority_queue] ERROR");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic test_pop_empty();
        gap_max   = 0;
        stall_pct = 0;
        send_req(REQ_POP, '1, '1);
        send_req(REQ_POP, '0, '0);
    endtask

    task automatic test_key_extremes();
        gap_max   = 3;
        stall_pct = 30;
        send_req(REQ_PUSH, 32'h0000_0000, 16'h0000);
        send_req(REQ_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(REQ_PUSH, 32'h0001_0000, 16'h1234);
        send_req(REQ_PUSH, 32'h0000_FFFF, 16'hABCD);
        repeat (5) send_req(REQ_POP, '0, '0);
    endtask

    task automatic test_equal_keys();
        gap_max   = 0;
        stall_pct = 50;
        send_req(REQ_PUSH, 32'd5, 16'd1);
        send_req(REQ_PUSH, 32'd5, 16'd2);
        send_req(REQ_PUSH, 32'd5, 16'd3);
        send_req(REQ_PUSH, 32'd3, 16'd4);
        send_req(REQ_PUSH, 32'd5, 16'd5);
        repeat (5) send_req(REQ_POP, '0, '0);
    endtask

    task automatic test_fill_to_full();
        gap_max   = 2;
        stall_pct = 20;
        repeat (DEPTH) send_req(REQ_PUSH, pick_key(), 16'($urandom));
        repeat (3) send_req(REQ_PUSH, pick_key(), 16'($urandom));
        send_req(REQ_POP, '0, '0);
        send_req(REQ_PUSH, pick_key(), 16'($urandom));
        send_req(REQ_PUSH, pick_key(), 16'($urandom));
        repeat (DEPTH + 2) send_req(REQ_POP, '0, '0);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int unsigned phase_len;
        int unsigned push_pct;
        logic        req;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 140);
            case ($urandom_range(0, 3))
                0: push_pct = 85;
                1: push_pct = 15;
                2: push_pct = 50;
                default: push_pct = 65;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                gap_max   = 0;
                stall_pct = 0;
            end else begin
                gap_max   = $urandom_range(0, 6);
                stall_pct = $urandom_range(0, 70);
            end
            repeat (phase_len) begin
                req = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
                send_req(req, req == REQ_PUSH ? pick_key() : KEY_BITS'($urandom),
                         16'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        logic req;
        gap_max   = 0;
        stall_pct = 0;
        hold_asked++;
        repeat (40) begin
            req = $urandom_range(0, 2) == 0 ? REQ_POP : REQ_PUSH;
            send_req(req, pick_key(), 16'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pop_empty();
        test_key_extremes();
        test_equal_keys();
        test_fill_to_full();
        test_random_traffic();
        test_output_backpressure();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[sorted_min_priority_queue] OK");
        end else begin
            $display("[sorted_min_priority_queue] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
